/* rtl/dadz_pkg.sv */
// dadz_pkg: shared types, constants and calendar helpers for the date adder
// used by dadz_ctrl, dadz_dp and date_add_days_with_zodiac_core; no dependencies
`timescale 1ns / 1ps

package dadz_pkg;

	localparam logic [13:0] YEAR_CAP    = 14'd10000;
	localparam logic [9:0]  DAYS_RESET  = 10'd280;
	// floor(y / 100) == (y * RECIP_100) >> RECIP_SHIFT for every 14-bit y
	localparam logic [12:0] RECIP_100   = 13'd5243;
	localparam int          RECIP_SHIFT = 19;

	localparam logic [3:0] MONTH_JAN = 4'd1;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_DEC = 4'd12;

	localparam logic [3:0] SIGN_CAPRICORN = 4'd11;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP1,
		ST_PREP2,
		ST_STEP
	} state_t;

	typedef struct packed {
		logic load;
		logic prep1;
		logic prep2;
		logic step;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic last;
	} dp_status_t;

	// days in a month for a given leap flag
	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		begin
			case (m) inside
				4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
				MONTH_FEB:               len = leap ? 5'd29 : 5'd28;
				default:                 len = 5'd31;
			endcase
			return len;
		end
	endfunction

	// first day of the later sign within each month
	function automatic logic [4:0] sign_cut(input logic [3:0] m);
		logic [4:0] cut;
		begin
			case (m)
				4'd1:    cut = 5'd21;
				4'd2:    cut = 5'd20;
				4'd3:    cut = 5'd21;
				4'd4:    cut = 5'd21;
				4'd5:    cut = 5'd22;
				4'd6:    cut = 5'd22;
				4'd7:    cut = 5'd23;
				4'd8:    cut = 5'd22;
				4'd9:    cut = 5'd24;
				4'd10:   cut = 5'd24;
				4'd11:   cut = 5'd23;
				4'd12:   cut = 5'd23;
				default: cut = 5'd0;
			endcase
			return cut;
		end
	endfunction

	// zodiac code from month and day
	function automatic logic [3:0] sign_of(input logic [3:0] m, input logic [4:0] d);
		logic [3:0] code;
		begin
			if (d >= sign_cut(m))
				code = m - 4'd1;
			else if (m == MONTH_JAN)
				code = SIGN_CAPRICORN;
			else
				code = m - 4'd2;
			return code;
		end
	endfunction

endpackage

/* rtl/date_add_days_with_zodiac_core.sv */
// a date is taken in idle when start is high; ST_PREP1 (year / 100 quotient) and ST_PREP2
// (year residues) follow, then the month stepper walks one month a cycle up to the end month
// and the result is registered; no new date is taken until the controller is back in idle
// the done beat lasts one cycle and cannot be held off; busy is low while idle
// reset: asynchronous, active low; clears the controller and strobe, day count goes to 280
`timescale 1ns / 1ps

module date_add_days_with_zodiac_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [9:0]  cfg_wdata,
	input  logic        start,
	output logic        busy,
	input  logic [3:0]  start_month,
	input  logic [4:0]  start_day,
	input  logic [13:0] start_year,
	output logic        done,
	output logic [3:0]  end_month,
	output logic [4:0]  end_day,
	output logic [13:0] end_year,
	output logic [3:0]  sign_code
);

	dadz_pkg::ctrl_cmd_t  cmd;
	dadz_pkg::dp_status_t status;

	// controller
	dadz_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// datapath
	dadz_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.start_month (start_month),
		.start_day   (start_day),
		.start_year  (start_year),
		.cmd         (cmd),
		.status      (status),
		.done        (done),
		.end_month   (end_month),
		.end_day     (end_day),
		.end_year    (end_year),
		.sign_code   (sign_code)
	);

endmodule

/* rtl/dadz_ctrl.sv */
// dadz_ctrl: controller state machine for the date adder
// depends on dadz_pkg (state_t, ctrl_cmd_t, dp_status_t)
`timescale 1ns / 1ps

module dadz_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  dadz_pkg::dp_status_t  status,
	output dadz_pkg::ctrl_cmd_t   cmd,
	output logic                  busy
);

	dadz_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= dadz_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// next state and commands
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		busy       = 1'b1;
		case (state_q)
			dadz_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = dadz_pkg::ST_PREP1;
				end
			end
			dadz_pkg::ST_PREP1: begin
				cmd.prep1 = 1'b1;
				state_d   = dadz_pkg::ST_PREP2;
			end
			dadz_pkg::ST_PREP2: begin
				cmd.prep2 = 1'b1;
				state_d   = dadz_pkg::ST_STEP;
			end
			dadz_pkg::ST_STEP: begin
				cmd.step = 1'b1;
				if (status.last) begin
					cmd.finish = 1'b1;
					state_d    = dadz_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dadz_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/dadz_dp.sv */
// dadz_dp: datapath of the date adder, day count register, month stepper, sign lookup
// depends on dadz_pkg (constants, month_len, sign_of, command and status structs)
`timescale 1ns / 1ps

module dadz_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [9:0]            cfg_wdata,
	input  logic [3:0]            start_month,
	input  logic [4:0]            start_day,
	input  logic [13:0]           start_year,
	input  dadz_pkg::ctrl_cmd_t   cmd,
	output dadz_pkg::dp_status_t  status,
	output logic                  done,
	output logic [3:0]            end_month,
	output logic [4:0]            end_day,
	output logic [13:0]           end_year,
	output logic [3:0]            sign_code
);

	logic [9:0]  days_q;
	logic [3:0]  m_q;
	logic [4:0]  d_q;
	logic [13:0] y_q;
	logic [9:0]  left_q;
	logic [6:0]  quot_q;
	logic [6:0]  r100_q;
	logic [1:0]  cent_q;
	logic        done_q;

	logic [3:0]  m_in;
	logic [4:0]  d_in;
	logic [13:0] y_in;
	logic [26:0] prod;
	logic [13:0] hundreds;
	logic [13:0] rem_full;
	logic        leap;
	logic [4:0]  len;
	logic [4:0]  d_eff;
	logic [9:0]  k;
	logic        last;
	logic [4:0]  d_final;
	logic [9:0]  d_sum;

	// day count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			days_q <= dadz_pkg::DAYS_RESET;
		else if (cfg_we)
			days_q <= cfg_wdata;
	end

	// input clamping
	always_comb begin
		if (start_month == 4'd0)
			m_in = dadz_pkg::MONTH_JAN;
		else if (start_month > dadz_pkg::MONTH_DEC)
			m_in = dadz_pkg::MONTH_DEC;
		else
			m_in = start_month;
		d_in = (start_day == 5'd0) ? 5'd1 : start_day;
		y_in = (start_year > dadz_pkg::YEAR_CAP) ? dadz_pkg::YEAR_CAP : start_year;
	end

	// year / 100 by reciprocal, remainder from the registered quotient
	assign prod     = y_q * dadz_pkg::RECIP_100;
	assign hundreds = 14'(quot_q) * 14'd100;
	assign rem_full = y_q - hundreds;

	// leap flag from tracked year residues
	assign leap = (y_q[1:0] == 2'b00) && ((r100_q != 7'd0) || (cent_q == 2'b00));

	// one month step
	always_comb begin
		len     = dadz_pkg::month_len(m_q, leap);
		d_eff   = (d_q > len) ? len : d_q;
		k       = 10'(len) + 10'd1 - 10'(d_eff);
		last    = (left_q < k);
		d_sum   = 10'(d_eff) + left_q;
		d_final = d_sum[4:0];
	end

	assign status.last = last;

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m_q    <= m_in;
			d_q    <= d_in;
			y_q    <= y_in;
			left_q <= days_q;
		end
		if (cmd.prep1)
			quot_q <= prod[dadz_pkg::RECIP_SHIFT +: 7];
		if (cmd.prep2) begin
			r100_q <= rem_full[6:0];
			cent_q <= quot_q[1:0];
		end
		if (cmd.step && !last) begin
			left_q <= left_q - k;
			d_q    <= 5'd1;
			if (m_q == dadz_pkg::MONTH_DEC) begin
				m_q <= dadz_pkg::MONTH_JAN;
				if (y_q < dadz_pkg::YEAR_CAP) begin
					y_q <= y_q + 14'd1;
					if (r100_q == 7'd99) begin
						r100_q <= 7'd0;
						cent_q <= cent_q + 2'd1;
					end else begin
						r100_q <= r100_q + 7'd1;
					end
				end
			end else begin
				m_q <= m_q + 4'd1;
			end
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			end_month <= m_q;
			end_day   <= d_final;
			end_year  <= y_q;
			sign_code <= dadz_pkg::sign_of(m_q, d_final);
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= cmd.finish;
	end

	assign done = done_q;

	// result month stays in range
	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (end_month >= dadz_pkg::MONTH_JAN && end_month <= dadz_pkg::MONTH_DEC))
		else $error("end month out of range");

	// result day is never zero
	a_day_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (end_day != 5'd0))
		else $error("end day is zero");

	// year never passes the cap
	a_year_cap: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (end_year <= dadz_pkg::YEAR_CAP))
		else $error("end year above cap");

	// sign code is one of the twelve signs
	a_sign_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (sign_code <= dadz_pkg::SIGN_CAPRICORN))
		else $error("sign code out of range");

endmodule

/* sim/date_add_days_with_zodiac_core_tb.sv */
// self-checking bench for date_add_days_with_zodiac_core: adds a day count to dates, checks
// end date and zodiac sign per done beat; depends on dadz_pkg and the core rtl
`timescale 1ns / 1ps

module date_add_days_with_zodiac_core_tb;

	localparam logic [3:0] MONTH_APR = 4'd4;
	localparam logic [3:0] MONTH_JUN = 4'd6;
	localparam logic [3:0] MONTH_SEP = 4'd9;
	localparam logic [3:0] MONTH_NOV = 4'd11;

	localparam int N_PHASES       = 7;
	localparam int PHASE_DATES    = 64;
	localparam int DRAIN_EVERY    = 40;
	localparam int SETTLE_CYCLES  = 8;
	localparam int TAIL_CYCLES    = 45;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int REPORT_MAX     = 10;

	typedef struct packed {
		logic [3:0]  month;
		logic [4:0]  day;
		logic [13:0] year;
	} date_t;

	typedef struct packed {
		logic [3:0]  month;
		logic [4:0]  day;
		logic [13:0] year;
		logic [3:0]  sign;
	} zdate_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [9:0]  cfg_wdata = '0;
	logic        start = 1'b0;
	logic [3:0]  start_month = '0;
	logic [4:0]  start_day = '0;
	logic [13:0] start_year = '0;
	logic        busy;
	logic        done;
	logic [3:0]  end_month;
	logic [4:0]  end_day;
	logic [13:0] end_year;
	logic [3:0]  sign_code;

	// dates waiting to be sent, and end dates waiting to come back
	date_t  pending_dates[$];
	zdate_t expected_dates[$];

	logic [9:0] span_model = dadz_pkg::DAYS_RESET;
	int         idle_pct = 0;
	logic       took_item = 1'b0;
	logic       drain_wait = 1'b0;
	int         launched = 0;
	int         accepted = 0;
	int         checked = 0;
	int         err_count = 0;
	int         stall_cycles = 0;

	date_add_days_with_zodiac_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.start       (start),
		.busy        (busy),
		.start_month (start_month),
		.start_day   (start_day),
		.start_year  (start_year),
		.done        (done),
		.end_month   (end_month),
		.end_day     (end_day),
		.end_year    (end_year),
		.sign_code   (sign_code)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// gregorian 4/100/400 rule
	function automatic logic is_leap_year(input logic [13:0] y);
		if (y % 4 != 0)
			return 1'b0;
		return (y % 100 != 0) || (y % 400 == 0);
	endfunction

	function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic [13:0] y);
		if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV)
			return 5'd30;
		if (m == dadz_pkg::MONTH_FEB)
			return is_leap_year(y) ? 5'd29 : 5'd28;
		return 5'd31;
	endfunction

	// first day of the month that belongs to the later sign
	function automatic logic [4:0] sign_boundary(input logic [3:0] m);
		case (m)
			4'd1, 4'd3, 4'd4:  return 5'd21;
			4'd2:              return 5'd20;
			4'd5, 4'd6, 4'd8:  return 5'd22;
			4'd7, 4'd11, 4'd12: return 5'd23;
			default:           return 5'd24;
		endcase
	endfunction

	// clamp the start date, then walk forward a month at a time
	function automatic zdate_t date_plus_days(input date_t from, input logic [9:0] span);
		logic [3:0]  m;
		logic [4:0]  d;
		logic [13:0] y;
		logic [9:0]  left;
		logic [5:0]  to_next;
		logic [4:0]  wrapped;
		zdate_t      r;
		m = from.month;
		d = from.day;
		y = from.year;
		if (m == 4'd0)
			m = dadz_pkg::MONTH_JAN;
		if (m > dadz_pkg::MONTH_DEC)
			m = dadz_pkg::MONTH_DEC;
		if (y > dadz_pkg::YEAR_CAP)
			y = dadz_pkg::YEAR_CAP;
		if (d == 5'd0)
			d = 5'd1;
		if (d > days_in_month(m, y))
			d = days_in_month(m, y);
		left = span;
		while (left != 10'd0) begin
			to_next = {1'b0, days_in_month(m, y)} + 6'd1 - {1'b0, d};
			if (left >= to_next) begin
				left = left - to_next;
				d = 5'd1;
				if (m == dadz_pkg::MONTH_DEC) begin
					m = dadz_pkg::MONTH_JAN;
					if (y < dadz_pkg::YEAR_CAP)
						y = y + 14'd1;
				end else begin
					m = m + 4'd1;
				end
			end else begin
				d = d + left[4:0];
				left = 10'd0;
			end
		end
		wrapped = ({1'b0, m} + 5'd10) % 5'd12;
		r.month = m;
		r.day = d;
		r.year = y;
		r.sign = (d >= sign_boundary(m)) ? m - 4'd1 : wrapped[3:0];
		return r;
	endfunction

	// mostly valid dates, biased to month ends, centuries and the top years
	function automatic date_t random_date();
		date_t t;
		int    pick;
		pick = $urandom_range(99);
		if (pick < 12) begin
			t.month = 4'($urandom_range(15));
			t.day = 5'($urandom_range(31));
			t.year = 14'($urandom_range(16383));
		end else begin
			t.month = 4'($urandom_range(12, 1));
			if (pick < 26)
				t.year = 14'($urandom_range(10000, 9985));
			else if (pick < 40)
				t.year = 14'($urandom_range(99) * 100);
			else
				t.year = 14'($urandom_range(9999));
			if (pick < 50)
				t.day = days_in_month(t.month, t.year);
			else
				t.day = 5'($urandom_range(days_in_month(t.month, t.year), 1));
		end
		return t;
	endfunction

	// driver: one date per beat, held until the block takes it
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !took_item) begin
			// beat still waiting for busy to drop
		end else if (pending_dates.size() == 0 || drain_wait || $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			start_month <= 4'($urandom_range(15));
			start_day <= 5'($urandom_range(31));
			start_year <= 14'($urandom_range(16383));
			if (drain_wait && expected_dates.size() == 0)
				drain_wait = 1'b0;
		end else begin
			start <= 1'b1;
			{start_month, start_day, start_year} <= pending_dates[0];
			launched++;
			if (launched % DRAIN_EVERY == 0)
				drain_wait = 1'b1;
		end
	end

	// monitor: record accepted beats, check done beats in order
	always @(posedge clk) begin : monitor
		zdate_t got;
		zdate_t want;
		if (arst_n) begin
			took_item <= start && !busy;
			if (done) begin
				got = {end_month, end_day, end_year, sign_code};
				if (expected_dates.size() == 0) begin
					err_count++;
					if (err_count <= REPORT_MAX)
						$display("%0t: unexpected done beat: %0d/%0d/%0d sign %0d", $time,
							got.month, got.day, got.year, got.sign);
				end else begin
					want = expected_dates.pop_front();
					checked++;
					if (got.month !== want.month || got.day !== want.day ||
							got.year !== want.year || got.sign !== want.sign) begin
						err_count++;
						if (err_count <= REPORT_MAX)
							$display("%0t: mismatch: expected %0d/%0d/%0d sign %0d, got %0d/%0d/%0d sign %0d",
								$time, want.month, want.day, want.year, want.sign,
								got.month, got.day, got.year, got.sign);
					end
				end
			end
			if (start && !busy) begin
				expected_dates.push_back(date_plus_days({start_month, start_day, start_year},
					span_model));
				void'(pending_dates.pop_front());
				accepted++;
			end
			stall_cycles = (done || (start && !busy)) ? 0 : stall_cycles + 1;
		end
	end

	// watchdog on cycles with no beat in either direction
	initial begin
		while (stall_cycles < WATCHDOG_LIMIT)
			@(negedge clk);
		$display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	// phases: day count and sender idling per phase
	initial begin
		int unsigned span_plan [N_PHASES];
		int          idle_plan [N_PHASES];
		span_plan = '{280, 0, 1023, 1, 365, 59, 0};
		span_plan[N_PHASES - 1] = $urandom_range(1022, 2);
		idle_plan = '{0, 65, 0, 35, 65, 0, 35};
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < N_PHASES; p++) begin
			// register writes only with the block idle and nothing outstanding
			if (p != 0) begin
				while (pending_dates.size() != 0 || expected_dates.size() != 0)
					@(negedge clk);
				repeat (SETTLE_CYCLES) @(negedge clk);
				cfg_we <= 1'b1;
				cfg_wdata <= span_plan[p][9:0];
				@(negedge clk);
				cfg_we <= 1'b0;
			end
			@(posedge clk);
			span_model = span_plan[p][9:0];
			idle_pct = idle_plan[p];
			if (p == 0) begin
				// field extremes and clamping cases at the reset day count
				pending_dates.push_back({dadz_pkg::MONTH_JAN, 5'd1, 14'd0});
				pending_dates.push_back({dadz_pkg::MONTH_DEC, 5'd31, 14'd9999});
				pending_dates.push_back({4'd0, 5'd0, 14'd0});
				pending_dates.push_back({4'd15, 5'd31, 14'd16383});
				pending_dates.push_back({4'd13, 5'd15, 14'd2024});
				pending_dates.push_back({dadz_pkg::MONTH_FEB, 5'd29, 14'd1900});
				pending_dates.push_back({dadz_pkg::MONTH_FEB, 5'd29, 14'd2000});
				pending_dates.push_back({dadz_pkg::MONTH_FEB, 5'd31, 14'd2004});
				pending_dates.push_back({MONTH_APR, 5'd31, 14'd2021});
				pending_dates.push_back({MONTH_NOV, 5'd30, 14'd10000});
				pending_dates.push_back({dadz_pkg::MONTH_DEC, 5'd31, 14'd10000});
				pending_dates.push_back({dadz_pkg::MONTH_FEB, 5'd29, 14'd10001});
				pending_dates.push_back({MONTH_JUN, 5'd22, 14'd2023});
				pending_dates.push_back({4'd5, 5'd21, 14'd1999});
				pending_dates.push_back({dadz_pkg::MONTH_DEC, 5'd0, 14'd16000});
			end
			for (int i = 0; i < PHASE_DATES; i++)
				pending_dates.push_back(random_date());
		end
		while (pending_dates.size() != 0 || expected_dates.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (expected_dates.size() != 0) begin
			err_count += expected_dates.size();
			$display("%0d end dates never came back", expected_dates.size());
		end
		$display("covered %0d dates over %0d day counts, 0 and 1023 among them", accepted,
			N_PHASES);
		$display("%0d end dates compared, %0d mismatches", checked, err_count);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* sim.f */
rtl/dadz_pkg.sv
rtl/dadz_ctrl.sv
rtl/dadz_dp.sv
rtl/date_add_days_with_zodiac_core.sv
sim/date_add_days_with_zodiac_core_tb.sv
